### rtl/polygon_centroid_macros.svh
// Assertion macros used by the polygon centroid top level.
`ifndef POLYGON_CENTROID_MACROS_SVH
`define POLYGON_CENTROID_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define PC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define PC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/pc_pkg.sv
// Package with widths, the accumulated-sum record and the back-end state type.
package pc_pkg;

  localparam int PC_COORD_W    = 16;
  localparam int PC_AREA_W     = 48;
  localparam int PC_MOM_W      = 64;
  localparam int PC_QUEUE_DEPTH = 2;

  // Finished sums of one polygon, passed from the front to the back.
  typedef struct packed {
    logic signed [PC_AREA_W-1:0] area;
    logic signed [PC_MOM_W-1:0]  mom_x;
    logic signed [PC_MOM_W-1:0]  mom_y;
  } sums_t;

  // Back-end sequencer states.
  typedef enum logic [2:0] {
    BK_IDLE,
    BK_LOAD,
    BK_SCALE,
    BK_DIVIDE,
    BK_FINISH
  } back_state_t;

endpackage

### rtl/polygon_centroid.sv
// Top level of the streaming polygon centroid block.
//
// Vertices arrive on the s_ channel, one per transaction: s_tdata holds x in
// bits 15:0 and y in bits 31:16 (signed Q12.4), s_tlast marks the vertex that
// closes the polygon. Each closed polygon yields one transaction on the m_
// channel: centroid x in m_tdata[15:0], centroid y in m_tdata[31:16] (Q12.4,
// truncated toward zero and saturated), m_tuser set for a zero-area polygon.
// The front takes one vertex per cycle into a four-stage multiply-accumulate
// pipe; after the closing vertex it takes no vertex while it inserts the
// edge back to the first vertex. Sums of finished polygons wait in a short
// queue. The back divides with a one-bit-per-cycle restoring divider, both
// coordinates side by side. A zero-area polygon skips the divider.
// A stalled m_ channel holds the result; the back keeps dividing into its
// output stage, then the queue fills and finally s_tready drops.
// Synchronous reset clears all sums, the queue and the output valid.
module polygon_centroid
  import pc_pkg::*;
#(
  parameter int QUEUE_DEPTH = PC_QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // vertex_x [15:0], vertex_y [31:16]
  input  logic        s_tlast,   // last_vertex
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // centroid_x [15:0], centroid_y [31:16]
  output logic [0:0]  m_tuser    // degenerate [0]
);

`include "polygon_centroid_macros.svh"

  logic  q_push, q_full, q_pop, q_empty;
  sums_t q_in, q_head;
  logic [15:0] cx, cy;
  logic        degen;

  pc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .vx        (s_tdata[15:0]),
    .vy        (s_tdata[31:16]),
    .in_last   (s_tlast),
    .push      (q_push),
    .push_data (q_in),
    .q_full    (q_full)
  );

  pc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty)
  );

  pc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (q_head),
    .empty     (q_empty),
    .pop       (q_pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_cx    (cx),
    .out_cy    (cy),
    .out_degen (degen)
  );

  assign m_tdata = {cy, cx};
  assign m_tuser = degen;

  // A closing vertex blocks the input while the closing edge is inserted.
  `PC_ASSERT_NEXT(a_close_gap, s_tvalid && s_tready && s_tlast, !s_tready, "input taken during closing edge")
  // The front never hands sums to a full queue.
  `PC_ASSERT_NOW(a_no_overflow, q_push, !q_full, "push into full queue")
  // A degenerate result carries zero coordinates.
  `PC_ASSERT_NOW(a_degen_zero, m_tvalid && m_tuser[0], m_tdata == 32'h0, "degenerate result not zero")
  // The back pops only when the queue has an entry.
  `PC_ASSERT_NOW(a_no_underflow, q_pop, !q_empty, "pop from empty queue")

endmodule

### rtl/pc_front.sv
// Front end: takes vertices, forms edges and accumulates the shoelace sums.
module pc_front
  import pc_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [PC_COORD_W-1:0] vx,
  input  logic signed [PC_COORD_W-1:0] vy,
  input  logic                         in_last,
  output logic                         push,
  output sums_t                        push_data,
  input  logic                         q_full
);

  // Vertex bookkeeping.
  logic signed [PC_COORD_W-1:0] first_x, first_y, prev_x, prev_y;
  logic                         have_first;
  logic                         close_pending;

  // Stage 1: edge endpoints.
  logic                         s1_valid, s1_close;
  logic signed [PC_COORD_W-1:0] s1_x0, s1_y0, s1_x1, s1_y1;
  // Stage 2: cross products and endpoint sums.
  logic                         s2_valid, s2_close;
  logic signed [31:0]           s2_pa, s2_pb;
  logic signed [16:0]           s2_sx, s2_sy;
  // Stage 3: cross product difference.
  logic                         s3_valid, s3_close;
  logic signed [32:0]           s3_c;
  logic signed [16:0]           s3_sx, s3_sy;
  // Stage 4: moment terms.
  logic                         s4_valid, s4_close;
  logic signed [32:0]           s4_c;
  logic signed [49:0]           s4_tx, s4_ty;

  // Accumulators.
  logic signed [PC_AREA_W-1:0] acc_a;
  logic signed [PC_MOM_W-1:0]  acc_x, acc_y;

  logic adv;
  logic accept;
  logic inject;

  // The whole pipe halts only when a closing edge finds the queue full.
  assign adv      = !(s4_valid && s4_close && q_full);
  assign in_ready = adv && !close_pending;
  assign accept   = in_valid && in_ready;
  assign inject   = close_pending && adv;

  // Sums including the term now leaving stage 4.
  assign push_data.area  = acc_a + PC_AREA_W'(s4_c);
  assign push_data.mom_x = acc_x + PC_MOM_W'(s4_tx);
  assign push_data.mom_y = acc_y + PC_MOM_W'(s4_ty);
  assign push            = adv && s4_valid && s4_close;

  // Vertex state and the one-cycle insertion of the closing edge.
  always_ff @(posedge clk) begin
    if (rst) begin
      have_first    <= 1'b0;
      close_pending <= 1'b0;
      first_x       <= '0;
      first_y       <= '0;
      prev_x        <= '0;
      prev_y        <= '0;
    end else if (inject) begin
      close_pending <= 1'b0;
      have_first    <= 1'b0;
    end else if (accept) begin
      if (!have_first) begin
        first_x <= vx;
        first_y <= vy;
      end
      prev_x     <= vx;
      prev_y     <= vy;
      have_first <= 1'b1;
      if (in_last) begin
        close_pending <= 1'b1;
      end
    end
  end

  // Valid bits of the pipeline.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= accept || inject;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
    end
  end

  // Pipeline payload.
  always_ff @(posedge clk) begin
    if (adv) begin
      if (inject) begin
        s1_x0    <= prev_x;
        s1_y0    <= prev_y;
        s1_x1    <= first_x;
        s1_y1    <= first_y;
        s1_close <= 1'b1;
      end else begin
        s1_x0    <= have_first ? prev_x : vx;
        s1_y0    <= have_first ? prev_y : vy;
        s1_x1    <= vx;
        s1_y1    <= vy;
        s1_close <= 1'b0;
      end
      s2_pa    <= 32'(s1_x0) * 32'(s1_y1);
      s2_pb    <= 32'(s1_x1) * 32'(s1_y0);
      s2_sx    <= 17'(s1_x0) + 17'(s1_x1);
      s2_sy    <= 17'(s1_y0) + 17'(s1_y1);
      s2_close <= s1_close;
      s3_c     <= 33'(s2_pa) - 33'(s2_pb);
      s3_sx    <= s2_sx;
      s3_sy    <= s2_sy;
      s3_close <= s2_close;
      s4_c     <= s3_c;
      s4_tx    <= 50'(s3_sx) * 50'(s3_c);
      s4_ty    <= 50'(s3_sy) * 50'(s3_c);
      s4_close <= s3_close;
    end
  end

  // Accumulate each edge; a closing edge hands the sums on and clears them.
  always_ff @(posedge clk) begin
    if (rst) begin
      acc_a <= '0;
      acc_x <= '0;
      acc_y <= '0;
    end else if (adv && s4_valid) begin
      if (s4_close) begin
        acc_a <= '0;
        acc_x <= '0;
        acc_y <= '0;
      end else begin
        acc_a <= push_data.area;
        acc_x <= push_data.mom_x;
        acc_y <= push_data.mom_y;
      end
    end
  end

endmodule

### rtl/pc_queue.sv
// Short queue of finished polygon sums between the front and the back.
module pc_queue
  import pc_pkg::*;
#(
  parameter int DEPTH = PC_QUEUE_DEPTH
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  sums_t push_data,
  output logic  full,
  input  logic  pop,
  output sums_t head,
  output logic  empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  sums_t           entries [DEPTH];
  logic [PW-1:0]   wr_ptr, rd_ptr;
  logic [CW-1:0]   count;
  logic            do_push, do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = entries[rd_ptr];

  // Storage writes.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### rtl/pc_back.sv
// Back end: divides the moments by three times the doubled area, one bit a cycle.
module pc_back
  import pc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  sums_t       head,
  input  logic        empty,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_cx,
  output logic [15:0] out_cy,
  output logic        out_degen
);

  localparam int DIV_STEPS = PC_MOM_W;
  localparam int SW        = $clog2(DIV_STEPS);
  localparam int DW        = PC_AREA_W + 1;

  back_state_t state, state_next;

  logic signed [PC_AREA_W-1:0] area;
  logic [PC_AREA_W-1:0]        amag;
  logic [DW-1:0]               den;
  logic [PC_MOM_W-1:0]         quo_x, quo_y;
  logic [DW-1:0]               rem_x, rem_y;
  logic                        neg_x, neg_y, degen;
  logic [SW-1:0]               step;

  logic [DW:0]   sh_x, sh_y;
  logic          fit_x, fit_y;
  logic          load_out;

  // Saturate a quotient magnitude with its sign to the signed 16-bit range.
  function automatic logic [15:0] sat16(input logic [PC_MOM_W-1:0] q, input logic neg);
    logic big;
    logic [15:0] r;
    if (!neg) begin
      big = |q[PC_MOM_W-1:15];
      r   = big ? 16'h7FFF : q[15:0];
    end else begin
      big = (|q[PC_MOM_W-1:16]) || (q[15] && (|q[14:0]));
      r   = big ? 16'h8000 : (~q[15:0] + 16'd1);
    end
    return r;
  endfunction

  // One restoring step per lane.
  assign sh_x  = {rem_x, quo_x[PC_MOM_W-1]};
  assign sh_y  = {rem_y, quo_y[PC_MOM_W-1]};
  assign fit_x = (sh_x >= {1'b0, den});
  assign fit_y = (sh_y >= {1'b0, den});

  assign load_out = (state == BK_FINISH) && (!out_valid || out_ready);

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and queue pop.
  always_comb begin
    state_next = state;
    pop        = 1'b0;
    case (state)
      BK_IDLE: begin
        if (!empty) begin
          pop        = 1'b1;
          state_next = BK_LOAD;
        end
      end
      BK_LOAD: begin
        state_next = BK_SCALE;
      end
      BK_SCALE: begin
        state_next = degen ? BK_FINISH : BK_DIVIDE;
      end
      BK_DIVIDE: begin
        if (step == SW'(DIV_STEPS - 1)) begin
          state_next = BK_FINISH;
        end
      end
      BK_FINISH: begin
        if (load_out) begin
          state_next = BK_IDLE;
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  // Division datapath.
  always_ff @(posedge clk) begin
    case (state)
      BK_IDLE: begin
        area  <= head.area;
        quo_x <= head.mom_x;
        quo_y <= head.mom_y;
      end
      BK_LOAD: begin
        // Take magnitudes; the quotient sign is the xor of the operand signs.
        neg_x <= quo_x[PC_MOM_W-1] ^ area[PC_AREA_W-1];
        neg_y <= quo_y[PC_MOM_W-1] ^ area[PC_AREA_W-1];
        quo_x <= quo_x[PC_MOM_W-1] ? (~quo_x + 1'b1) : quo_x;
        quo_y <= quo_y[PC_MOM_W-1] ? (~quo_y + 1'b1) : quo_y;
        amag  <= area[PC_AREA_W-1] ? PC_AREA_W'(~area + 1'b1) : PC_AREA_W'(area);
        degen <= (area == '0);
      end
      BK_SCALE: begin
        den   <= DW'(amag) + {amag, 1'b0};
        rem_x <= '0;
        rem_y <= '0;
        step  <= '0;
      end
      BK_DIVIDE: begin
        rem_x <= fit_x ? DW'(sh_x - {1'b0, den}) : sh_x[DW-1:0];
        rem_y <= fit_y ? DW'(sh_y - {1'b0, den}) : sh_y[DW-1:0];
        quo_x <= {quo_x[PC_MOM_W-2:0], fit_x};
        quo_y <= {quo_y[PC_MOM_W-2:0], fit_y};
        step  <= step + 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Output register; it is refilled only when empty or being taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_degen <= degen;
      out_cx    <= degen ? 16'h0000 : sat16(quo_x, neg_x);
      out_cy    <= degen ? 16'h0000 : sat16(quo_y, neg_y);
    end
  end

endmodule

### dv/tb_polygon_centroid.sv
// Self-checking testbench for the streaming polygon centroid block.
module tb_polygon_centroid
  import pc_pkg::*;
();

  // Kinds of random polygon content.
  typedef enum int {
    SHAPE_WIDE,
    SHAPE_CLUSTER,
    SHAPE_LINE,
    SHAPE_POINT
  } shape_t;

  // One expected centroid transaction.
  typedef struct {
    logic signed [PC_COORD_W-1:0] cx;
    logic signed [PC_COORD_W-1:0] cy;
    logic                         degen;
  } centroid_t;

  localparam int COORD_MIN = -32768;
  localparam int COORD_MAX = 32767;
  localparam int RANDOM_ITEMS = 1750;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;   // vertex_x [15:0], vertex_y [31:16]
  logic        s_tlast = 1'b0; // last_vertex
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;        // centroid_x [15:0], centroid_y [31:16]
  logic [0:0]  m_tuser;        // degenerate [0]

  // Stall rates in percent for the vertex sender and the result receiver.
  int idle_pct = 0;
  int stall_pct = 0;
  int mismatch_count = 0;

  // Shadow of the accumulation state.
  longint                      first_x, first_y, prev_x, prev_y;
  bit                          have_first = 1'b0;
  logic signed [PC_AREA_W-1:0] area_acc = '0;
  longint                      moment_x_acc = 0;
  longint                      moment_y_acc = 0;

  centroid_t expected_centroids[$];

  polygon_centroid DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // Clock with a 10 unit period.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // The receiver stalls at random at the current rate.
  always @(posedge clk) begin
    m_tready <= !rst && ($urandom_range(99) >= stall_pct);
  end

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $realtime, what);
    mismatch_count++;
  endtask

  // Adds one edge to the doubled area and the two moments.
  function automatic void accumulate_edge(longint x0, longint y0, longint x1, longint y1);
    longint c;
    c = x0 * y1 - x1 * y0;
    area_acc = area_acc + c[PC_AREA_W-1:0];
    moment_x_acc = moment_x_acc + (x0 + x1) * c;
    moment_y_acc = moment_y_acc + (y0 + y1) * c;
  endfunction

  // Quotient truncated toward zero and saturated to the Q12.4 range.
  function automatic logic signed [PC_COORD_W-1:0] scaled_quotient(longint num, longint den);
    longint q;
    q = num / den;
    if (q > COORD_MAX) q = COORD_MAX;
    if (q < COORD_MIN) q = COORD_MIN;
    return q[PC_COORD_W-1:0];
  endfunction

  // Folds one accepted vertex into the shadow state; a closing vertex
  // yields the expected centroid and clears the state.
  function automatic void take_vertex(logic signed [15:0] vx, logic signed [15:0] vy,
                                      bit closing);
    longint    x, y, area;
    centroid_t res;
    x = longint'(vx);
    y = longint'(vy);
    if (!have_first) begin
      first_x = x;
      first_y = y;
      prev_x = x;
      prev_y = y;
      have_first = 1'b1;
    end
    accumulate_edge(prev_x, prev_y, x, y);
    prev_x = x;
    prev_y = y;
    if (closing) begin
      accumulate_edge(x, y, first_x, first_y);
      area = longint'(area_acc);
      if (area == 0) begin
        res.cx = '0;
        res.cy = '0;
        res.degen = 1'b1;
      end else begin
        res.cx = scaled_quotient(moment_x_acc, 3 * area);
        res.cy = scaled_quotient(moment_y_acc, 3 * area);
        res.degen = 1'b0;
      end
      expected_centroids.push_back(res);
      have_first = 1'b0;
      area_acc = '0;
      moment_x_acc = 0;
      moment_y_acc = 0;
    end
  endfunction

  // Sends one vertex transaction. Valid stays high on return so that a
  // following vertex can go out back to back.
  task automatic send_vertex(input int x, input int y, input bit closing);
    logic [15:0] vx, vy;
    vx = x[15:0];
    vy = y[15:0];
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {vy, vx};
    s_tlast <= closing;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    take_vertex(vx, vy, closing);
  endtask

  function automatic int clamp_coord(int v);
    if (v > COORD_MAX) return COORD_MAX;
    if (v < COORD_MIN) return COORD_MIN;
    return v;
  endfunction

  function automatic int any_coord();
    return int'($urandom_range(65535)) - 32768;
  endfunction

  // Sends a polygon of n vertices with content of the given kind.
  task automatic send_polygon(input int n, input shape_t shape);
    int cx, cy, radius, dx, dy, t, x, y;
    cx = any_coord();
    cy = any_coord();
    case ($urandom_range(2))
      0: radius = 15;
      1: radius = 255;
      default: radius = 4095;
    endcase
    dx = int'($urandom_range(128)) - 64;
    dy = int'($urandom_range(128)) - 64;
    for (int i = 0; i < n; i++) begin
      case (shape)
        SHAPE_WIDE: begin
          x = any_coord();
          y = any_coord();
        end
        SHAPE_CLUSTER: begin
          x = clamp_coord(cx + int'($urandom_range(2 * radius)) - radius);
          y = clamp_coord(cy + int'($urandom_range(2 * radius)) - radius);
        end
        SHAPE_LINE: begin
          // Every point on one line, so the area is exactly zero.
          t = $urandom_range(300);
          x = cx / 4 + t * dx;
          y = cy / 4 + t * dy;
        end
        default: begin
          x = cx;
          y = cy;
        end
      endcase
      send_vertex(x, y, i == n - 1);
    end
  endtask

  // Lone vertices and a two-vertex polygon have no area.
  task automatic test_single_and_pair_vertices();
    send_vertex(COORD_MIN, COORD_MIN, 1'b1);
    send_vertex(COORD_MAX, COORD_MAX, 1'b1);
    send_vertex(COORD_MIN, COORD_MAX, 1'b0);
    send_vertex(COORD_MAX, COORD_MIN, 1'b1);
  endtask

  // Full-range triangle and squares in both winding directions.
  task automatic test_simple_shapes();
    send_vertex(COORD_MIN, COORD_MIN, 1'b0);
    send_vertex(COORD_MAX, COORD_MIN, 1'b0);
    send_vertex(0, COORD_MAX, 1'b1);
    send_vertex(0, 0, 1'b0);
    send_vertex(160, 0, 1'b0);
    send_vertex(160, 160, 1'b0);
    send_vertex(0, 160, 1'b1);
    send_vertex(0, 160, 1'b0);
    send_vertex(160, 160, 1'b0);
    send_vertex(160, 0, 1'b0);
    send_vertex(0, 0, 1'b1);
  endtask

  // Collinear points, and a self-crossing outline whose net area is tiny
  // so that the quotient runs past the coordinate range.
  task automatic test_crossing_and_saturation();
    send_vertex(-100, -50, 1'b0);
    send_vertex(300, 150, 1'b0);
    send_vertex(100, 50, 1'b1);
    send_vertex(0, 0, 1'b0);
    send_vertex(32000, 32000, 1'b0);
    send_vertex(32000, 0, 1'b0);
    send_vertex(0, 32001, 1'b1);
  endtask

  // Random polygons, mostly small, a few with up to 300 vertices.
  task automatic test_random_polygons(input int send_idle, input int recv_stall,
                                      input int budget);
    int     sent, n, pick;
    shape_t shape;
    sent = 0;
    idle_pct = send_idle;
    stall_pct = recv_stall;
    while (sent < budget) begin
      pick = $urandom_range(199);
      if (pick < 8) n = $urandom_range(2, 1);
      else if (pick < 176) n = $urandom_range(12, 3);
      else if (pick < 194) n = $urandom_range(64, 13);
      else if (pick < 198) n = $urandom_range(256, 65);
      else n = $urandom_range(300, 257);
      pick = $urandom_range(99);
      if (pick < 55) shape = SHAPE_CLUSTER;
      else if (pick < 70) shape = SHAPE_LINE;
      else if (pick < 75) shape = SHAPE_POINT;
      else shape = SHAPE_WIDE;
      send_polygon(n, shape);
      sent += n;
    end
  endtask

  // Compare each result transaction with the oldest expected centroid.
  always @(posedge clk) begin : check_results
    centroid_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_centroids.size() == 0) begin
        report_mismatch($sformatf("unexpected result %h/%b", m_tdata, m_tuser));
      end else begin
        want = expected_centroids.pop_front();
        if (m_tdata[15:0] !== want.cx)
          report_mismatch($sformatf("centroid_x %0d, want %0d",
                                    $signed(m_tdata[15:0]), want.cx));
        if (m_tdata[31:16] !== want.cy)
          report_mismatch($sformatf("centroid_y %0d, want %0d",
                                    $signed(m_tdata[31:16]), want.cy));
        if (m_tuser[0] !== want.degen)
          report_mismatch($sformatf("degenerate %b, want %b", m_tuser[0], want.degen));
      end
    end
  end

  // Main sequence.
  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_single_and_pair_vertices();
    test_simple_shapes();
    test_crossing_and_saturation();
    test_random_polygons(0, 0, RANDOM_ITEMS / 4);
    test_random_polygons(81, 0, RANDOM_ITEMS / 4);
    test_random_polygons(0, 81, RANDOM_ITEMS / 4);
    test_random_polygons(13, 13, RANDOM_ITEMS / 4);
    s_tvalid <= 1'b0;
    s_tlast <= 1'b0;
    stall_pct = 0;
    while (expected_centroids.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (mismatch_count == 0)
      $display("polygon_centroid verification clean");
    else
      $display("polygon_centroid verification failed");
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #20_000_000;
    $display("polygon_centroid verification failed");
    $finish;
  end

endmodule
